// ===== design/sbeu_pkg.sv =====
// shared types, codes and constants for the stack bytecode execute unit
package sbeu_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int LOCAL_SLOTS_DEF = 16;
	localparam logic [4:0] SLOT_LIMIT_RST = 5'd16;
	localparam logic [0:0] REG_SLOT_LIMIT = 1'd0;

	typedef enum logic [3:0] {
		OP_LOAD = 4'd0, OP_STORE = 4'd1, OP_PUSH = 4'd2, OP_ADD = 4'd3,
		OP_INC = 4'd4, OP_SUB = 4'd5, OP_MUL = 4'd6, OP_DIV = 4'd7,
		OP_RET = 4'd8, OP_CMPGE = 4'd9, OP_GOTO = 4'd10
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0, ERR_SLOT = 3'd1, ERR_UNDER = 3'd2, ERR_OVER = 3'd3,
		ERR_DIVZ = 3'd4
	} err_t;

	typedef struct packed {
		logic [3:0]  func;
		logic [7:0]  slot_index;
		logic [63:0] imm_value;
		logic [7:0]  inc_amount;
		logic [15:0] branch_target;
	} in_item_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [63:0] top_value;
		logic [4:0]  stack_level;
		logic        halted;
		logic [2:0]  error_code;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_FIN, ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic read;
		logic exec;
		logic mul_step;
		logic div_start;
		logic div_step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic halted;
		logic is_mul;
		logic is_div;
		logic div_done;
	} status_t;

endpackage

// ===== design/sbeu_datapath.sv =====
// datapath: operand stack, local slots, pc, alu and iterative divider
module sbeu_datapath #(
	parameter int STACK_DEPTH = sbeu_pkg::STACK_DEPTH_DEF,
	parameter int LOCAL_SLOTS = sbeu_pkg::LOCAL_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sbeu_pkg::in_item_t in_item,
	input  sbeu_pkg::cmd_t     cmd,
	input  logic [4:0]         slot_limit,
	output sbeu_pkg::status_t  status,
	output sbeu_pkg::out_item_t out_item
);
	import sbeu_pkg::*;

	localparam int SW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int LW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

	logic [63:0] stack_mem [STACK_DEPTH];
	logic [63:0] slots_q [LOCAL_SLOTS];
	logic [CW-1:0] count_q;
	logic [15:0] pc_q;
	logic halt_q;
	logic [63:0] top_cache_q;
	err_t err_q;

	in_item_t item_q;
	logic [63:0] top_q, second_q, slotv_q;
	logic slot_ok_q;

	logic [63:0] res_q, mul_acc_q;
	logic [1:0]  mul_cnt_q;
	logic [63:0] quo_q, rem_q;
	logic [6:0]  div_cnt_q;

	logic [SW-1:0] sec_idx;
	logic [LW-1:0] slot_idx;
	logic slot_ok;

	assign sec_idx = SW'(count_q - CW'(2));
	assign slot_idx = LW'(item_q.slot_index);
	assign slot_ok = ({1'b0, item_q.slot_index} < {4'd0, slot_limit})
		&& ({24'd0, item_q.slot_index} < 32'(LOCAL_SLOTS));

	assign status.halted = halt_q;
	assign status.is_mul = item_q.func == OP_MUL;
	assign status.is_div = item_q.func == OP_DIV && count_q >= CW'(2)
		&& top_q != 64'd0;
	assign status.div_done = div_cnt_q == 7'd0;

	// 16x64 partial product per step, four steps
	logic [15:0] mul_dig;
	always_comb begin
		case (mul_cnt_q)
			2'd0: mul_dig = top_q[15:0];
			2'd1: mul_dig = top_q[31:16];
			2'd2: mul_dig = top_q[47:32];
			default: mul_dig = top_q[63:48];
		endcase
	end

	logic [64:0] rem_try;
	assign rem_try = {rem_q, quo_q[63]} - {1'b0, top_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_item;
		if (cmd.read) begin
			top_q <= top_cache_q;
			second_q <= stack_mem[sec_idx];
			slotv_q <= slots_q[slot_idx];
			slot_ok_q <= slot_ok;
			mul_acc_q <= '0;
			mul_cnt_q <= '0;
		end
		if (cmd.mul_step) begin
			mul_acc_q <= mul_acc_q + ((second_q * {48'd0, mul_dig})
				<< {mul_cnt_q, 4'd0});
			mul_cnt_q <= mul_cnt_q + 2'd1;
		end
		if (cmd.div_start) begin
			quo_q <= second_q;
			rem_q <= '0;
			div_cnt_q <= 7'd64;
		end else if (cmd.div_step) begin
			if (!rem_try[64]) begin
				rem_q <= rem_try[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pc_q <= '0;
			halt_q <= 1'b0;
			top_cache_q <= '0;
			for (int i = 0; i < LOCAL_SLOTS; i++) slots_q[i] <= '0;
			err_q <= ERR_OK;
		end else if (cmd.finish) begin
			err_t err;
			logic [15:0] pc;
			logic [63:0] r;
			err = ERR_OK;
			pc = pc_q;
			r = '0;
			if (halt_q) begin
				err_q <= ERR_OK;
			end else begin
				case (item_q.func)
					OP_LOAD: begin
						pc = pc_q + 16'd2;
						if (!slot_ok_q) err = ERR_SLOT;
						else if (count_q >= CW'(STACK_DEPTH)) err = ERR_OVER;
						else begin
							stack_mem[SW'(count_q)] <= slotv_q;
							top_cache_q <= slotv_q;
							count_q <= count_q + CW'(1);
						end
					end
					OP_STORE: begin
						pc = pc_q + 16'd2;
						if (!slot_ok_q) err = ERR_SLOT;
						else if (count_q == '0) err = ERR_UNDER;
						else begin
							slots_q[slot_idx] <= top_q;
							top_cache_q <= (count_q >= CW'(2)) ? second_q : 64'd0;
							count_q <= count_q - CW'(1);
						end
					end
					OP_PUSH: begin
						pc = pc_q + 16'd9;
						if (count_q >= CW'(STACK_DEPTH)) err = ERR_OVER;
						else begin
							stack_mem[SW'(count_q)] <= item_q.imm_value;
							top_cache_q <= item_q.imm_value;
							count_q <= count_q + CW'(1);
						end
					end
					OP_INC: begin
						pc = pc_q + 16'd3;
						if (!slot_ok_q) err = ERR_SLOT;
						else slots_q[slot_idx] <= slotv_q + {56'd0, item_q.inc_amount};
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
						pc = pc_q + 16'd1;
						case (item_q.func)
							OP_ADD: r = second_q + top_q;
							OP_SUB: r = second_q - top_q;
							OP_MUL: r = mul_acc_q;
							default: r = quo_q;
						endcase
						if (count_q < CW'(2)) err = ERR_UNDER;
						else if (item_q.func == OP_DIV && top_q == '0) err = ERR_DIVZ;
						else begin
							stack_mem[sec_idx] <= r;
							top_cache_q <= r;
							count_q <= count_q - CW'(1);
						end
					end
					OP_CMPGE: begin
						pc = pc_q + 16'd3;
						if (count_q < CW'(2)) err = ERR_UNDER;
						else begin
							if (second_q >= top_q) pc = item_q.branch_target;
							top_cache_q <= (count_q >= CW'(3))
								? stack_mem[SW'(count_q - CW'(3))] : 64'd0;
							count_q <= count_q - CW'(2);
						end
					end
					OP_RET: halt_q <= 1'b1;
					OP_GOTO: pc = item_q.branch_target;
					default: pc = pc_q + 16'd1;
				endcase
				pc_q <= pc;
				err_q <= err;
			end
		end
	end

	// result fields follow the committed state
	assign out_item.next_pc = pc_q;
	assign out_item.top_value = (count_q != '0) ? top_cache_q : 64'd0;
	assign out_item.stack_level = 5'(count_q);
	assign out_item.halted = halt_q;
	assign out_item.error_code = err_q;
endmodule

// ===== design/sbeu_control.sv =====
// controller state machine sequencing read, execute and result transfer
module sbeu_control (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  sbeu_pkg::status_t status,
	output sbeu_pkg::cmd_t    cmd
);
	import sbeu_pkg::*;

	state_t state_q, state_d;
	logic [1:0] mcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mcnt_q <= '0;
		end else begin
			state_q <= state_d;
			mcnt_q <= (state_q == ST_MUL) ? mcnt_q + 2'd1 : 2'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!status.halted && status.is_mul) state_d = ST_MUL;
				else if (!status.halted && status.is_div) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.finish = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (mcnt_q == 2'd3) state_d = ST_FIN;
			end
			ST_DIV: begin
				if (status.div_done) begin
					cmd.finish = 1'b1;
					state_d = ST_OUT;
				end else cmd.div_step = 1'b1;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== design/stack_bytecode_execute_unit.sv =====
// top level of the stack bytecode execute unit
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_stall   | sbeu_pkg::in_item_t
// out     | out | out_valid/out_stall | sbeu_pkg::out_item_t
// cfg     | in  | apb write/read      | slot limit at byte 0
// an item goes through transfer in, stack read, execute and result transfer
// mul adds the steps of the 16-bit partial product unit, div adds the steps
// of the radix-2 divider
// reset clears stack count, pc, halt flag and all local slots at once
// a stalled result holds and no item is taken until it has gone
module stack_bytecode_execute_unit #(
	parameter int STACK_DEPTH = sbeu_pkg::STACK_DEPTH_DEF,
	parameter int LOCAL_SLOTS = sbeu_pkg::LOCAL_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sbeu_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sbeu_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [0:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import sbeu_pkg::*;

	cmd_t cmd;
	status_t status;
	logic [4:0] slot_limit_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SLOT_LIMIT) ? {27'd0, slot_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slot_limit_q <= SLOT_LIMIT_RST;
		else if (psel && penable && pwrite && paddr == REG_SLOT_LIMIT)
			slot_limit_q <= pwdata[4:0];
	end

	sbeu_control u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	sbeu_datapath #(.STACK_DEPTH(STACK_DEPTH), .LOCAL_SLOTS(LOCAL_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd),
		.slot_limit(slot_limit_q), .status(status), .out_item(out_data)
	);
endmodule

// ===== tb/sbeu_result_check.sv =====
// result predictor and comparator for the stack bytecode execute unit
module sbeu_result_check (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  sbeu_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  sbeu_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [0:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  pending,
	output int                  fail_count
);
	import sbeu_pkg::*;

	logic [63:0] opstack [16];
	logic [63:0] slots [16];
	int          depth;
	logic [15:0] pc_now;
	logic        halt_now;
	logic [4:0]  locals_used;
	out_item_t   expected_q [$];

	function automatic out_item_t execute_instr(in_item_t it);
		out_item_t   res;
		err_t        err;
		logic [15:0] pc;
		logic [63:0] t;
		logic [63:0] s;
		bit          slot_ok;
		err = ERR_OK;
		pc = pc_now;
		slot_ok = (it.slot_index < locals_used) && (it.slot_index < 16);
		if (!halt_now) begin
			case (it.func)
				OP_LOAD: begin
					if (!slot_ok) err = ERR_SLOT;
					else if (depth >= 16) err = ERR_OVER;
					else begin
						opstack[depth] = slots[it.slot_index[3:0]];
						depth++;
					end
					pc += 16'd2;
				end
				OP_STORE: begin
					if (!slot_ok) err = ERR_SLOT;
					else if (depth == 0) err = ERR_UNDER;
					else begin
						depth--;
						slots[it.slot_index[3:0]] = opstack[depth];
					end
					pc += 16'd2;
				end
				OP_PUSH: begin
					if (depth >= 16) err = ERR_OVER;
					else begin
						opstack[depth] = it.imm_value;
						depth++;
					end
					pc += 16'd9;
				end
				OP_INC: begin
					if (!slot_ok) err = ERR_SLOT;
					else slots[it.slot_index[3:0]] += 64'(it.inc_amount);
					pc += 16'd3;
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMPGE: begin
					if (depth < 2) begin
						err = ERR_UNDER;
						pc += (it.func == OP_CMPGE) ? 16'd3 : 16'd1;
					end else begin
						t = opstack[depth-1];
						s = opstack[depth-2];
						if (it.func == OP_CMPGE) begin
							depth -= 2;
							pc = (s >= t) ? it.branch_target : pc + 16'd3;
						end else if (it.func == OP_DIV && t == 0) begin
							err = ERR_DIVZ;
							pc += 16'd1;
						end else begin
							case (it.func)
								OP_ADD: s = s + t;
								OP_SUB: s = s - t;
								OP_MUL: s = s * t;
								default: s = s / t;
							endcase
							depth--;
							opstack[depth-1] = s;
							pc += 16'd1;
						end
					end
				end
				OP_RET: halt_now = 1'b1;
				OP_GOTO: pc = it.branch_target;
				default: pc += 16'd1;
			endcase
			pc_now = pc;
		end
		res.next_pc = pc_now;
		res.top_value = (depth > 0) ? opstack[depth-1] : 64'd0;
		res.stack_level = 5'(depth);
		res.halted = halt_now;
		res.error_code = err;
		return res;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) slots[i] = '0;
			depth = 0;
			pc_now = '0;
			halt_now = 1'b0;
			locals_used = SLOT_LIMIT_RST;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_SLOT_LIMIT)
				locals_used = pwdata[4:0];
			if (in_valid && !in_stall)
				expected_q = {expected_q, execute_instr(in_data)};
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (out_data.next_pc !== want.next_pc) begin
						$error("next_pc: expected %0h, got %0h", want.next_pc, out_data.next_pc);
						fail_count++;
					end
					if (out_data.top_value !== want.top_value) begin
						$error("top_value: expected %0h, got %0h",
							want.top_value, out_data.top_value);
						fail_count++;
					end
					if (out_data.stack_level !== want.stack_level) begin
						$error("stack_level: expected %0d, got %0d",
							want.stack_level, out_data.stack_level);
						fail_count++;
					end
					if (out_data.halted !== want.halted) begin
						$error("halted: expected %0b, got %0b", want.halted, out_data.halted);
						fail_count++;
					end
					if (out_data.error_code !== want.error_code) begin
						$error("error_code: expected %0d, got %0d",
							want.error_code, out_data.error_code);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
// stimulus, idling and verdict for the stack bytecode execute unit
module tb;
	import sbeu_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [0:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          pending;
	int          fail_count;
	int          cycles;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          sent;

	stack_bytecode_execute_unit dut (.*);

	sbeu_result_check u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic in_item_t make_instr(logic [3:0] f);
		in_item_t it;
		it.func = f;
		it.slot_index = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(17));
		case ($urandom_range(3))
			0: it.imm_value = {$urandom, $urandom};
			1: it.imm_value = 64'($urandom_range(3));
			2: it.imm_value = ~64'($urandom_range(3));
			default: it.imm_value = 64'($urandom_range(1000));
		endcase
		it.inc_amount = 8'($urandom);
		it.branch_target = 16'($urandom);
		return it;
	endfunction

	task automatic send(in_item_t it);
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_op(logic [3:0] f);
		send(make_instr(f));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_locals(logic [4:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= REG_SLOT_LIMIT;
		pwdata <= 32'(v);
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic directed_run;
		in_item_t it;
		it = make_instr(OP_PUSH); it.imm_value = '1; send(it);
		it = make_instr(OP_PUSH); it.imm_value = '0; send(it);
		send_op(OP_DIV);
		send_op(OP_CMPGE);
		send_op(OP_ADD);
		it = make_instr(OP_PUSH); it.imm_value = '1; send(it);
		send_op(OP_PUSH);
		send_op(OP_ADD);
		it = make_instr(OP_STORE); it.slot_index = 8'd0; send(it);
		it = make_instr(OP_STORE); it.slot_index = 8'd255; send(it);
		it = make_instr(OP_INC); it.slot_index = 8'd15; it.inc_amount = 8'hff; send(it);
		it = make_instr(OP_LOAD); it.slot_index = 8'd15; send(it);
		it = make_instr(OP_LOAD); it.slot_index = 8'd16; send(it);
		it = make_instr(OP_LOAD); it.slot_index = 8'd0; send(it);
		send_op(OP_SUB);
		send_op(OP_PUSH);
		send_op(OP_MUL);
		send_op(OP_PUSH);
		send_op(OP_DIV);
		it = make_instr(OP_GOTO); it.branch_target = 16'hffff; send(it);
		send_op(OP_PUSH);
		send_op(4'd11);
		send_op(4'd15);
		it = make_instr(OP_STORE); it.slot_index = 8'd3; send(it);
		send_op(OP_STORE);
	endtask

	task automatic random_run(int n);
		int start;
		int k;
		logic [3:0] f;
		start = sent;
		while (sent - start < n) begin
			k = $urandom_range(99);
			if (k < 40) begin
				send_op($urandom_range(1) ? OP_PUSH : OP_LOAD);
				send_op($urandom_range(1) ? OP_PUSH : OP_LOAD);
				case ($urandom_range(4))
					0: send_op(OP_ADD);
					1: send_op(OP_SUB);
					2: send_op(OP_MUL);
					3: send_op(OP_DIV);
					default: send_op(OP_CMPGE);
				endcase
				if ($urandom_range(1)) send_op(OP_STORE);
			end else if (k < 45) begin
				repeat ($urandom_range(14, 18)) send_op(OP_PUSH);
			end else if (k < 50) begin
				repeat ($urandom_range(4, 18)) send_op(OP_ADD + 4'(2 * $urandom_range(2)));
			end else if (k < 60) begin
				send_op(OP_INC);
				send_op(OP_LOAD);
			end else begin
				f = 4'($urandom_range(15));
				if (f == OP_RET) f = OP_GOTO;
				send_op(f);
			end
		end
	endtask

	initial begin
		logic [4:0] locals_plan [6];
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		sent = 0;
		send_idle_pct = 26;
		recv_stall_pct = 53;
		locals_plan = '{5'd0, 5'd16, 5'd1, 5'd7, 5'd16, 5'd12};
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_run();
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_locals(locals_plan[ph]);
			if (ph == 2) begin
				send_idle_pct = 53;
				recv_stall_pct = 26;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			random_run(170);
		end
		drain();
		send_op(OP_RET);
		repeat (3) send_op($urandom_range(1) ? OP_PUSH : OP_GOTO);
		drain();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
